/* hw/rtl/frl_pkg.sv */
// ---------------------------------------------------------------------------
// frl_pkg
// Shared constants, codes and types of the frame recency list.
// ---------------------------------------------------------------------------
package frl_pkg;

   // frame index and link widths
   localparam int FRAME_W    = 6;
   localparam int MAX_FRAMES = 64;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int LINK_W     = IDX_W + 1;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_FRAMES);

   // frames-in-use register
   localparam int CSR_W = 7;
   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(64);

   // stream widths
   localparam int CMD_W = 2;
   localparam int REQ_W = 8;
   localparam int RSP_W = 16;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      OP_PUSH_BACK = 2'd0,
      OP_REMOVE    = 2'd1,
      OP_MOVE_BACK = 2'd2,
      OP_POP_FRONT = 2'd3
   } frl_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UNLINK,
      ST_LINK_A,
      ST_LINK_B,
      ST_RESULT
   } frl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic applied;
      logic pop;
      logic read;
      logic unlink;
      logic link_a;
      logic link_b;
      logic load_rsp;
   } frl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      frl_op_type op;
      logic       frame_ok;
      logic       frame_member;
      logic       frame_tail;
      logic       head_valid;
      logic       out_free;
   } frl_status_type;

   // a link names a frame when it is below the null value
   function automatic logic is_link(input logic [LINK_W-1:0] v);
      return v < NULL_LINK;
   endfunction

endpackage

/* hw/rtl/frame_recency_list.sv */
// ---------------------------------------------------------------------------
// frame_recency_list
// Recency order of physical frames kept as an index-linked double list.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one command beat (push back, remove, move to back,
//    pop front) with a frame index; frames at or above frames_in_use are
//    ignored by push, remove and move.
//  - rsp channel: exactly one result beat per command, in order.
//  - csr port: csr_wen writes frames_in_use; write only while idle.
// Steps per command: an ignored command or a move of the tail goes
//  straight to the result; push writes the new member's links, then
//  hooks it behind the old tail; remove and pop read the links, then
//  unlink; a move of a non-tail member reads, unlinks, then links. The
//  steps are set by the single write port of each link RAM and its registered read.
// The result appears in the same cycle as the next command can be taken.
// Reset empties the list (membership flags clear, head and tail null) and
// sets frames_in_use to 64; the link RAMs need no clearing pass.
// A stalled rsp side holds the result register; a further command is
// still accepted and runs, then waits with its result until the
// register frees.
// ---------------------------------------------------------------------------
module frame_recency_list (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [1:0] cmd, [7:2] frame
   input  logic [frl_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [5:0] frame_out, [6] frame_valid, [7] op_applied, [8] list_empty
   output logic [frl_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_wen,
   input  logic [frl_pkg::CSR_W-1:0]    csr_wdata
);

   frl_pkg::frl_cmd_type    cmd;
   frl_pkg::frl_status_type status;

   // sequencer
   frl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // list storage and result register
   frl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef SYNTHESIS
   // one command at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("command accepted while another is in flight");

   // a popped frame is always an applied operation
   a_pop_applied: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6]) |-> rsp_tdata[7])
      else $error("frame returned without op_applied");

   // no frame returned means frame_out reads zero
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[6]) |-> (rsp_tdata[5:0] == 6'd0))
      else $error("frame_out not zero without a popped frame");

   // result channel is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");
`endif

endmodule

/* hw/rtl/frl_ram.sv */
// ---------------------------------------------------------------------------
// frl_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module frl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/frl_ctrl.sv */
// ---------------------------------------------------------------------------
// frl_ctrl
// Sequencer of the frame recency list: decides the steps of each command.
// ---------------------------------------------------------------------------
module frl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  frl_pkg::frl_status_type status,
   output frl_pkg::frl_cmd_type    cmd
);

   frl_pkg::frl_state_type state_ff, state_in;
   logic                   relink_ff, relink_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= frl_pkg::ST_IDLE;
         relink_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         relink_ff <= relink_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      relink_in = relink_ff;
      unique case (state_ff)
         frl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               relink_in = 1'b0;
               state_in  = frl_pkg::ST_RESULT;
               unique case (status.op)
                  frl_pkg::OP_PUSH_BACK: begin
                     if (status.frame_ok && !status.frame_member) begin
                        state_in = frl_pkg::ST_LINK_A;
                     end
                  end
                  frl_pkg::OP_REMOVE: begin
                     if (status.frame_ok && status.frame_member) begin
                        state_in = frl_pkg::ST_READ;
                     end
                  end
                  frl_pkg::OP_MOVE_BACK: begin
                     if (status.frame_ok && status.frame_member && !status.frame_tail) begin
                        state_in  = frl_pkg::ST_READ;
                        relink_in = 1'b1;
                     end
                  end
                  frl_pkg::OP_POP_FRONT: begin
                     if (status.head_valid) begin
                        state_in = frl_pkg::ST_READ;
                     end
                  end
                  default: state_in = frl_pkg::ST_RESULT;
               endcase
            end
         end
         frl_pkg::ST_READ:   state_in = frl_pkg::ST_UNLINK;
         frl_pkg::ST_UNLINK: state_in = relink_ff ? frl_pkg::ST_LINK_A : frl_pkg::ST_RESULT;
         frl_pkg::ST_LINK_A: state_in = frl_pkg::ST_LINK_B;
         frl_pkg::ST_LINK_B: state_in = frl_pkg::ST_RESULT;
         frl_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = frl_pkg::ST_IDLE;
            end
         end
         default: state_in = frl_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         frl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            unique case (status.op)
               frl_pkg::OP_PUSH_BACK: begin
                  cmd.applied = status.frame_ok && !status.frame_member;
               end
               frl_pkg::OP_REMOVE, frl_pkg::OP_MOVE_BACK: begin
                  cmd.applied = status.frame_ok && status.frame_member;
               end
               frl_pkg::OP_POP_FRONT: begin
                  cmd.applied = status.head_valid;
                  cmd.pop     = status.head_valid;
               end
               default: cmd.applied = 1'b0;
            endcase
         end
         frl_pkg::ST_READ:   cmd.read     = 1'b1;
         frl_pkg::ST_UNLINK: cmd.unlink   = 1'b1;
         frl_pkg::ST_LINK_A: cmd.link_a   = 1'b1;
         frl_pkg::ST_LINK_B: cmd.link_b   = 1'b1;
         frl_pkg::ST_RESULT: cmd.load_rsp = status.out_free;
         default:            cmd          = '0;
      endcase
   end

endmodule

/* hw/rtl/frl_dp.sv */
// ---------------------------------------------------------------------------
// frl_dp
// Datapath of the frame recency list: link RAMs, membership, head, tail,
// frames-in-use register and the result register.
// ---------------------------------------------------------------------------
module frl_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [frl_pkg::REQ_W-1:0]   req_tdata,
   output logic [frl_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_wen,
   input  logic [frl_pkg::CSR_W-1:0]   csr_wdata,
   input  frl_pkg::frl_cmd_type        cmd,
   output frl_pkg::frl_status_type     status
);

   localparam int IDX_W  = frl_pkg::IDX_W;
   localparam int LINK_W = frl_pkg::LINK_W;

   logic [frl_pkg::CSR_W-1:0]   fiu_ff;
   logic [LINK_W-1:0]           head_ff, head_in;
   logic [LINK_W-1:0]           tail_ff, tail_in;
   logic [frl_pkg::MAX_FRAMES-1:0] member_ff, member_in;
   logic [IDX_W-1:0]            target_ff;
   logic                        applied_ff;
   logic                        popped_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [frl_pkg::RSP_W-1:0]   rsp_data_ff;

   logic [frl_pkg::CMD_W-1:0]   req_cmd;
   logic [frl_pkg::FRAME_W-1:0] req_frame;
   logic [LINK_W-1:0]           prev_q, next_q;
   logic                        nx_wen, pv_wen;
   logic [IDX_W-1:0]            nx_waddr, pv_waddr;
   logic [LINK_W-1:0]           nx_wdata, pv_wdata;
   logic [LINK_W-1:0]           target_link;

   // request fields
   assign req_cmd     = req_tdata[frl_pkg::CMD_W-1:0];
   assign req_frame   = req_tdata[frl_pkg::CMD_W +: frl_pkg::FRAME_W];
   assign target_link = {1'b0, target_ff};

   // status towards the sequencer
   always_comb begin
      status.op           = frl_pkg::frl_op_type'(req_cmd);
      status.frame_ok     = (frl_pkg::CSR_W'(req_frame) < fiu_ff) &&
                            (LINK_W'(req_frame) < frl_pkg::NULL_LINK);
      status.frame_member = member_ff[IDX_W'(req_frame)];
      status.frame_tail   = tail_ff == LINK_W'(req_frame);
      status.head_valid   = frl_pkg::is_link(head_ff);
      status.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // frames-in-use register
   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= frl_pkg::CSR_RESET;
      end else if (csr_wen) begin
         fiu_ff <= csr_wdata;
      end
   end

   // latched command operands
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         target_ff  <= cmd.pop ? head_ff[IDX_W-1:0] : IDX_W'(req_frame);
         applied_ff <= cmd.applied;
         popped_ff  <= cmd.pop;
      end
   end

   // link RAM write ports
   always_comb begin
      nx_wen   = 1'b0;
      nx_waddr = target_ff;
      nx_wdata = frl_pkg::NULL_LINK;
      pv_wen   = 1'b0;
      pv_waddr = target_ff;
      pv_wdata = tail_ff;
      priority if (cmd.link_a) begin
         // new member: no successor, predecessor is the tail
         nx_wen = 1'b1;
         pv_wen = 1'b1;
      end else if (cmd.link_b) begin
         // old tail points forward to the new member
         nx_wen   = frl_pkg::is_link(tail_ff);
         nx_waddr = tail_ff[IDX_W-1:0];
         nx_wdata = target_link;
      end else if (cmd.unlink) begin
         // neighbours bypass the removed frame
         nx_wen   = frl_pkg::is_link(prev_q);
         nx_waddr = prev_q[IDX_W-1:0];
         nx_wdata = next_q;
         pv_wen   = frl_pkg::is_link(next_q);
         pv_waddr = next_q[IDX_W-1:0];
         pv_wdata = prev_q;
      end else begin
         nx_wen = 1'b0;
         pv_wen = 1'b0;
      end
   end

   // next and previous link stores
   frl_ram #(.WIDTH(LINK_W), .DEPTH(frl_pkg::MAX_FRAMES)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_wen),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_en   (cmd.read),
      .rd_addr (target_ff),
      .rd_data (next_q)
   );

   frl_ram #(.WIDTH(LINK_W), .DEPTH(frl_pkg::MAX_FRAMES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_wen),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_en   (cmd.read),
      .rd_addr (target_ff),
      .rd_data (prev_q)
   );

   // head, tail and membership updates
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      member_in = member_ff;
      priority if (cmd.unlink) begin
         if (!frl_pkg::is_link(prev_q)) begin
            head_in = next_q;
         end
         if (!frl_pkg::is_link(next_q)) begin
            tail_in = prev_q;
         end
         member_in[target_ff] = 1'b0;
      end else if (cmd.link_a) begin
         member_in[target_ff] = 1'b1;
      end else if (cmd.link_b) begin
         if (!frl_pkg::is_link(tail_ff)) begin
            head_in = target_link;
         end
         tail_in = target_link;
      end else begin
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= frl_pkg::NULL_LINK;
         tail_ff   <= frl_pkg::NULL_LINK;
         member_ff <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         member_ff <= member_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {7'd0,
                         !frl_pkg::is_link(head_ff),
                         applied_ff,
                         popped_ff,
                         popped_ff ? target_ff : IDX_W'(0)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sim/frame_recency_checker.sv */
// ---------------------------------------------------------------------------
// frame_recency_checker
// Watches the req, rsp and csr ports of the frame recency list, keeps its
// own copy of the linked order and membership, and compares every rsp beat
// field by field with the oldest predicted outcome.
// ---------------------------------------------------------------------------
module frame_recency_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // [1:0] cmd, [7:2] frame
   input  logic [frl_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [5:0] frame_out, [6] frame_valid, [7] op_applied, [8] list_empty
   input  logic [frl_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_wen,
   input  logic [frl_pkg::CSR_W-1:0]   csr_wdata,
   output int                          fail_count,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [frl_pkg::FRAME_W-1:0] frame_out;
      logic                        frame_valid;
      logic                        op_applied;
      logic                        list_empty;
   } step_outcome_type;

   // shadow of the recency order
   logic [frl_pkg::LINK_W-1:0] next_of [frl_pkg::MAX_FRAMES];
   logic [frl_pkg::LINK_W-1:0] prev_of [frl_pkg::MAX_FRAMES];
   logic                       member  [frl_pkg::MAX_FRAMES];
   logic [frl_pkg::LINK_W-1:0] head_idx;
   logic [frl_pkg::LINK_W-1:0] tail_idx;
   logic [frl_pkg::CSR_W-1:0]  frames_in_use;

   step_outcome_type awaited_outcomes[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // take a member out of the order, closing the gap
   task automatic unlink_from_order(input logic [frl_pkg::IDX_W-1:0] f);
      logic [frl_pkg::LINK_W-1:0] p;
      logic [frl_pkg::LINK_W-1:0] n;
      p = prev_of[f];
      n = next_of[f];
      if (p < frl_pkg::NULL_LINK) next_of[p[frl_pkg::IDX_W-1:0]] = n;
      else head_idx = n;
      if (n < frl_pkg::NULL_LINK) prev_of[n[frl_pkg::IDX_W-1:0]] = p;
      else tail_idx = p;
      next_of[f] = frl_pkg::NULL_LINK;
      prev_of[f] = frl_pkg::NULL_LINK;
      member[f]  = 1'b0;
   endtask

   // hook a frame behind the current tail
   task automatic append_to_order(input logic [frl_pkg::IDX_W-1:0] f);
      prev_of[f] = tail_idx;
      next_of[f] = frl_pkg::NULL_LINK;
      if (tail_idx < frl_pkg::NULL_LINK)
         next_of[tail_idx[frl_pkg::IDX_W-1:0]] = frl_pkg::LINK_W'(f);
      else head_idx = frl_pkg::LINK_W'(f);
      tail_idx  = frl_pkg::LINK_W'(f);
      member[f] = 1'b1;
   endtask

   // advance the shadow by one command and work out its rsp beat
   task automatic apply_command(input frl_pkg::frl_op_type op,
                                input logic [frl_pkg::FRAME_W-1:0] f,
                                output step_outcome_type res);
      logic                       in_range;
      logic [frl_pkg::LINK_W-1:0] h;
      in_range = frl_pkg::CSR_W'(f) < frames_in_use;
      res = '0;
      case (op)
         frl_pkg::OP_PUSH_BACK: begin
            if (in_range && !member[f]) begin
               append_to_order(f);
               res.op_applied = 1'b1;
            end
         end
         frl_pkg::OP_REMOVE: begin
            if (in_range && member[f]) begin
               unlink_from_order(f);
               res.op_applied = 1'b1;
            end
         end
         frl_pkg::OP_MOVE_BACK: begin
            if (in_range && member[f]) begin
               if (tail_idx != frl_pkg::LINK_W'(f)) begin
                  unlink_from_order(f);
                  append_to_order(f);
               end
               res.op_applied = 1'b1;
            end
         end
         default: begin
            // pop takes the head whatever the register says
            h = head_idx;
            if (h < frl_pkg::NULL_LINK) begin
               unlink_from_order(h[frl_pkg::IDX_W-1:0]);
               res.frame_out   = h[frl_pkg::FRAME_W-1:0];
               res.frame_valid = 1'b1;
               res.op_applied  = 1'b1;
            end
         end
      endcase
      res.list_empty = !(head_idx < frl_pkg::NULL_LINK);
   endtask

   always @(posedge clock) begin
      step_outcome_type want;
      step_outcome_type got;
      if (reset) begin
         for (int i = 0; i < frl_pkg::MAX_FRAMES; i++) begin
            next_of[i] = frl_pkg::NULL_LINK;
            prev_of[i] = frl_pkg::NULL_LINK;
            member[i]  = 1'b0;
         end
         head_idx      = frl_pkg::NULL_LINK;
         tail_idx      = frl_pkg::NULL_LINK;
         frames_in_use = frl_pkg::CSR_RESET;
         awaited_outcomes.delete();
      end else begin
         // rsp beats belong to earlier commands, so compare first
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[5:0], rsp_tdata[6], rsp_tdata[7], rsp_tdata[8]};
            if (awaited_outcomes.size() == 0) begin
               report_mismatch($sformatf("rsp beat 0x%0h with nothing awaited", rsp_tdata));
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.frame_out !== want.frame_out)
                  report_mismatch($sformatf("frame_out %0d, expected %0d",
                                            got.frame_out, want.frame_out));
               if (got.frame_valid !== want.frame_valid)
                  report_mismatch($sformatf("frame_valid %0b, expected %0b",
                                            got.frame_valid, want.frame_valid));
               if (got.op_applied !== want.op_applied)
                  report_mismatch($sformatf("op_applied %0b, expected %0b",
                                            got.op_applied, want.op_applied));
               if (got.list_empty !== want.list_empty)
                  report_mismatch($sformatf("list_empty %0b, expected %0b",
                                            got.list_empty, want.list_empty));
            end
         end
         // register write
         if (csr_wen) frames_in_use = csr_wdata;
         // accepted command
         if (req_tvalid && req_tready) begin
            apply_command(frl_pkg::frl_op_type'(req_tdata[1:0]), req_tdata[7:2], want);
            awaited_outcomes.push_back(want);
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

/* sim/tb_frame_recency_list.sv */
// ---------------------------------------------------------------------------
// tb_frame_recency_list
// Drives directed and random command beats into the frame recency list
// through a range of frames_in_use settings, with random idling on both
// stream sides, and gives the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb_frame_recency_list;
   timeunit 1ns;
   timeprecision 1ps;

   // command mixes
   localparam int MIX_BALANCED = 0;
   localparam int MIX_FILL     = 1;
   localparam int MIX_DRAIN    = 2;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [frl_pkg::REQ_W-1:0]  req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [frl_pkg::RSP_W-1:0]  rsp_tdata;
   logic                       csr_wen;
   logic [frl_pkg::CSR_W-1:0]  csr_wdata;
   int                         fail_count;
   int                         outstanding;
   bit                         calm;

   frame_recency_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   frame_recency_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #500_000;
      $display("tb_frame_recency_list: errors");
      $finish;
   end

   // rsp side back-pressure in random bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one command beat, held until accepted
   task automatic send_command(input frl_pkg::frl_op_type op,
                               input logic [frl_pkg::FRAME_W-1:0] f);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {f, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // let the block run dry before touching the register
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_frames_in_use(input logic [frl_pkg::CSR_W-1:0] v);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // random commands, frames mostly from a window so that hits are common
   task automatic run_phase(input logic [frl_pkg::CSR_W-1:0] cfg, input int win,
                            input int count, input int mix);
      int r;
      int push_lim;
      int remove_lim;
      int move_lim;
      frl_pkg::frl_op_type op;
      logic [frl_pkg::FRAME_W-1:0] f;
      case (mix)
         MIX_FILL:  begin push_lim = 80; remove_lim = 80; move_lim = 95; end
         MIX_DRAIN: begin push_lim = 10; remove_lim = 20; move_lim = 30; end
         default:   begin push_lim = 35; remove_lim = 55; move_lim = 85; end
      endcase
      write_frames_in_use(cfg);
      repeat (count) begin
         if (!calm && $urandom_range(0, 6) == 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < push_lim) op = frl_pkg::OP_PUSH_BACK;
         else if (r < remove_lim) op = frl_pkg::OP_REMOVE;
         else if (r < move_lim) op = frl_pkg::OP_MOVE_BACK;
         else op = frl_pkg::OP_POP_FRONT;
         if ($urandom_range(0, 9) == 0) f = frl_pkg::FRAME_W'($urandom_range(0, 63));
         else f = frl_pkg::FRAME_W'($urandom_range(0, win));
         send_command(op, f);
      end
   endtask

   // stimulus
   initial begin
      calm       = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list cases, then order edits at the extremes
      write_frames_in_use(7'd64);
      send_command(frl_pkg::OP_POP_FRONT, 6'd0);
      send_command(frl_pkg::OP_REMOVE, 6'd5);
      send_command(frl_pkg::OP_MOVE_BACK, 6'd5);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd0);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd63);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd0);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd17);
      send_command(frl_pkg::OP_MOVE_BACK, 6'd63);
      send_command(frl_pkg::OP_MOVE_BACK, 6'd63);
      send_command(frl_pkg::OP_MOVE_BACK, 6'd0);
      send_command(frl_pkg::OP_REMOVE, 6'd63);
      send_command(frl_pkg::OP_POP_FRONT, 6'h3f);
      send_command(frl_pkg::OP_POP_FRONT, 6'd0);
      send_command(frl_pkg::OP_POP_FRONT, 6'd0);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd40);
      send_command(frl_pkg::OP_REMOVE, 6'd40);
      // frames just below, at and above the register
      write_frames_in_use(7'd8);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd8);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd7);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd63);
      send_command(frl_pkg::OP_MOVE_BACK, 6'd9);
      // register zero ignores every frame but pop still works
      write_frames_in_use(7'd0);
      send_command(frl_pkg::OP_PUSH_BACK, 6'd0);
      send_command(frl_pkg::OP_REMOVE, 6'd7);
      send_command(frl_pkg::OP_POP_FRONT, 6'd0);

      // random phases; the fill then drain pair leaves heads above the register
      run_phase(7'd64, 63, 100, MIX_BALANCED);
      run_phase(7'd1, 2, 50, MIX_BALANCED);
      run_phase(7'd8, 9, 100, MIX_BALANCED);
      run_phase(7'd0, 3, 30, MIX_BALANCED);
      run_phase(7'd16, 17, 100, MIX_BALANCED);
      run_phase(7'd64, 63, 60, MIX_FILL);
      run_phase(7'd4, 63, 60, MIX_DRAIN);
      run_phase(7'd2, 3, 60, MIX_BALANCED);
      calm = 1'b1;
      run_phase(7'd64, 12, 150, MIX_BALANCED);

      // wait for the last beats, then the verdict
      wait_drained();
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_frame_recency_list: clean");
      end else begin
         $display("tb_frame_recency_list: errors");
      end
      $finish;
   end

endmodule
